[hdl/timed_or_encoder_motor_move_assert.svh]
// Assertion macros shared by the motor move checker.
`ifndef TIMED_OR_ENCODER_MOTOR_MOVE_ASSERT_SVH
`define TIMED_OR_ENCODER_MOTOR_MOVE_ASSERT_SVH

// Next-cycle implication, ignored while reset is asserted.
`define TOMM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("motor move assertion failed");

// Next-cycle implication that is also checked across reset.
`define TOMM_ASSERT_RESET(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("motor move reset assertion failed");

`endif

[hdl/tomm_pkg.sv]
// Package for the timed or encoder-distance motor move block: widths, codes and types.
package tomm_pkg;

  localparam int TIME_WIDTH    = 16;
  localparam int ENCODER_WIDTH = 32;
  localparam int POWER_LIMIT   = 100;

  localparam int MODE_W   = 2;
  localparam int AMOUNT_W = 16;
  localparam int POWER_W  = 8;
  localparam int MV_W     = 14;
  localparam int ENC_W    = 32;

  // target must hold a sign-extended encoder value plus or minus the amount
  localparam int TGT_W  = ((ENCODER_WIDTH > AMOUNT_W) ? ENCODER_WIDTH : AMOUNT_W + 1) + 1;

  localparam int MAG_W  = POWER_W;
  localparam int PROD_W = MAG_W + MV_W;
  localparam int CNT_W  = $clog2(PROD_W);
  localparam int Q_W    = POWER_W;

  localparam logic [Q_W-1:0]  LIMIT_Q     = Q_W'(POWER_LIMIT);
  localparam logic [MV_W-1:0] REF_MV_INIT = MV_W'(7900);

  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TIMED = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DIST  = 2'd2;

  typedef enum logic [1:0] {
    KIND_IDLE  = 2'd0,
    KIND_TIMED = 2'd1,
    KIND_DIST  = 2'd2
  } kind_t;

  typedef struct packed {
    logic                      start;
    logic signed [POWER_W-1:0] power;
    logic [MV_W-1:0]           ref_mv;
    logic [MV_W-1:0]           bat_mv;
  } comp_req_t;

  typedef struct packed {
    logic                      done;
    logic signed [POWER_W-1:0] power;
  } comp_rsp_t;

endpackage

[hdl/tomm_if.sv]
// Valid/ready channel interfaces for command words and result words.
interface tomm_cmd_if import tomm_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [MODE_W-1:0]         mode;
  logic [AMOUNT_W-1:0]       move_amount;
  logic signed [POWER_W-1:0] start_power;
  logic signed [POWER_W-1:0] after_power;
  logic [MV_W-1:0]           ref_voltage_mv;
  logic signed [ENC_W-1:0]   encoder_count;
  logic [MV_W-1:0]           battery_mv;

  modport source (
    output valid, mode, move_amount, start_power, after_power,
           ref_voltage_mv, encoder_count, battery_mv,
    input  ready
  );
  modport sink (
    input  valid, mode, move_amount, start_power, after_power,
           ref_voltage_mv, encoder_count, battery_mv,
    output ready
  );
endinterface

interface tomm_res_if import tomm_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [POWER_W-1:0] motor_power;
  logic                      ready_res;

  modport source (output valid, motor_power, ready_res, input ready);
  modport sink   (input  valid, motor_power, ready_res, output ready);
endinterface

[hdl/tomm_comp.sv]
// Battery compensation unit: multiply, then a bit-serial restoring divide.
module tomm_comp import tomm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  comp_req_t req,
  output comp_rsp_t rsp
);

  typedef enum logic [1:0] {C_IDLE, C_MUL, C_SHIFT, C_FIN} cstate_t;

  cstate_t          state;
  logic [MAG_W-1:0] mag;
  logic             neg;
  logic             zero;
  logic [MV_W-1:0]  ref_mv;
  logic [MV_W-1:0]  bat_mv;
  logic [PROD_W-1:0] prod;
  logic [MV_W-1:0]  rem;
  logic [Q_W-1:0]   quo;
  logic             sat;
  logic [CNT_W-1:0] cnt;

  logic [MV_W:0]    trial;
  logic             take;
  logic [Q_W-1:0]   mag_q;
  logic [Q_W-1:0]   mag_lim;

  // shift one product bit into the partial remainder
  assign trial = {rem, prod[PROD_W-1]};
  assign take  = (trial >= {1'b0, bat_mv});

  always_comb begin
    mag_q = sat ? LIMIT_Q : quo;
    if (mag_q == '0) begin
      mag_lim = Q_W'(1);
    end else if (mag_q > LIMIT_Q) begin
      mag_lim = LIMIT_Q;
    end else begin
      mag_lim = mag_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= C_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      unique case (state)
        C_IDLE: begin
          if (req.start) begin
            mag    <= req.power[POWER_W-1] ? MAG_W'(~req.power + 1'b1) : MAG_W'(req.power);
            neg    <= req.power[POWER_W-1];
            zero   <= (req.power == '0);
            ref_mv <= req.ref_mv;
            bat_mv <= req.bat_mv;
            state  <= C_MUL;
          end
        end
        C_MUL: begin
          prod  <= PROD_W'(mag) * PROD_W'(ref_mv);
          rem   <= '0;
          quo   <= '0;
          sat   <= 1'b0;
          cnt   <= CNT_W'(PROD_W - 1);
          state <= C_SHIFT;
        end
        C_SHIFT: begin
          rem  <= take ? MV_W'(trial - {1'b0, bat_mv}) : trial[MV_W-1:0];
          prod <= {prod[PROD_W-2:0], 1'b0};
          // a bit leaving the top of the quotient means saturation
          sat  <= sat | quo[Q_W-1];
          quo  <= {quo[Q_W-2:0], take};
          if (cnt == '0) begin
            state <= C_FIN;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        C_FIN: begin
          if (zero) begin
            rsp.power <= '0;
          end else if (neg) begin
            rsp.power <= -$signed(mag_lim);
          end else begin
            rsp.power <= $signed(mag_lim);
          end
          rsp.done <= 1'b1;
          state    <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

[hdl/timed_or_encoder_motor_move.sv]
// Top level of one motor channel: timed or encoder-distance move control.
//
//   channel | dir | words carried
//   --------+-----+--------------------------------------------------------------
//   cmd     | in  | mode, move_amount, start/after power, ref mV, encoder, battery
//   res     | out | motor_power, ready_res (one word per command word)
//
// A start word, or a tick that ends a move, runs from its accept to the next accept
// through decode, the multiply, the bit-serial divide in tomm_comp, the saturation
// step, the pickup of the quotient, the output load and the return to idle. Any other
// tick runs through decode, the output load and the return to idle.
// Reset is synchronous; it clears the control state and leaves the channel idle.
// A stalled result holds in the output register; the next command word is taken
// meanwhile and waits at the output load until the held result is gone.
module timed_or_encoder_motor_move import tomm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  tomm_cmd_if.sink   cmd,
  tomm_res_if.source res
);

  typedef enum logic [1:0] {S_IDLE, S_EVAL, S_DIV, S_PUT} state_t;

  state_t state;

  // latched command word
  logic [MODE_W-1:0]         it_mode;
  logic [AMOUNT_W-1:0]       it_amount;
  logic signed [POWER_W-1:0] it_sp;
  logic signed [POWER_W-1:0] it_ap;
  logic [MV_W-1:0]           it_ref;
  logic signed [ENC_W-1:0]   it_enc;
  logic [MV_W-1:0]           it_bat;

  // move state
  kind_t                     kind;
  logic [TIME_WIDTH-1:0]     ticks_left;
  logic signed [TGT_W-1:0]   target;
  logic                      fwd;
  logic signed [POWER_W-1:0] held_ap;
  logic [MV_W-1:0]           held_ref;
  logic signed [POWER_W-1:0] drive;
  logic                      ready_flag;

  logic                      is_fin;
  logic signed [POWER_W-1:0] comp_power;
  logic                      res_valid;

  comp_req_t req;
  comp_rsp_t rsp;

  logic                    is_start;
  logic                    fin_now;
  logic                    sp_fwd;
  logic signed [TGT_W-1:0] enc_x;
  logic signed [TGT_W-1:0] amt_x;
  logic                    reached;
  logic                    out_free;

  assign is_start = (it_mode == MODE_TIMED) || (it_mode == MODE_DIST);
  assign sp_fwd   = !it_sp[POWER_W-1];
  assign enc_x    = TGT_W'($signed(it_enc[ENCODER_WIDTH-1:0]));
  assign amt_x    = TGT_W'(it_amount);
  assign reached  = fwd ? (enc_x >= target) : (enc_x <= target);

  // a tick ends a timed move on its last millisecond, a distance move on arrival
  always_comb begin
    fin_now = 1'b0;
    if (it_mode == MODE_TICK) begin
      unique case (kind)
        KIND_TIMED: fin_now = (ticks_left <= TIME_WIDTH'(1));
        KIND_DIST:  fin_now = reached;
        default:    fin_now = 1'b0;
      endcase
    end
  end

  // start words use their own power and reference; an ending tick uses the held ones
  assign req.start  = (state == S_EVAL) && (is_start || fin_now);
  assign req.power  = is_start ? it_sp : held_ap;
  assign req.ref_mv = is_start ? it_ref : held_ref;
  assign req.bat_mv = it_bat;

  tomm_comp u_comp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  assign out_free        = !res_valid || res.ready;
  assign cmd.ready       = (state == S_IDLE);
  assign res.valid       = res_valid;
  assign res.motor_power = drive;
  assign res.ready_res   = ready_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res_valid  <= 1'b0;
      kind       <= KIND_IDLE;
      ticks_left <= '0;
      target     <= '0;
      fwd        <= 1'b1;
      held_ap    <= '0;
      held_ref   <= REF_MV_INIT;
      drive      <= '0;
      ready_flag <= 1'b1;
      is_fin     <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            it_mode   <= cmd.mode;
            it_amount <= cmd.move_amount;
            it_sp     <= cmd.start_power;
            it_ap     <= cmd.after_power;
            it_ref    <= cmd.ref_voltage_mv;
            it_enc    <= cmd.encoder_count;
            it_bat    <= cmd.battery_mv;
            state     <= S_EVAL;
          end
        end
        S_EVAL: begin
          is_fin <= fin_now;
          state  <= (is_start || fin_now) ? S_DIV : S_PUT;
        end
        S_DIV: begin
          if (rsp.done) begin
            comp_power <= rsp.power;
            state      <= S_PUT;
          end
        end
        S_PUT: begin
          // commit only once the previous result word has left
          if (out_free) begin
            if (is_start) begin
              held_ap    <= it_ap;
              held_ref   <= it_ref;
              drive      <= comp_power;
              ready_flag <= 1'b0;
              fwd        <= sp_fwd;
              if (it_mode == MODE_TIMED) begin
                kind       <= KIND_TIMED;
                ticks_left <= TIME_WIDTH'(it_amount);
              end else begin
                kind       <= KIND_DIST;
                ticks_left <= '0;
                target     <= sp_fwd ? (enc_x + amt_x) : (enc_x - amt_x);
              end
            end else if (is_fin) begin
              drive      <= comp_power;
              ready_flag <= 1'b1;
              kind       <= KIND_IDLE;
              ticks_left <= '0;
            end else if (it_mode == MODE_TICK && kind == KIND_TIMED) begin
              ticks_left <= ticks_left - 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      // raise the result word on commit, drop it once taken
      if (state == S_PUT && out_free) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

[hdl/tomm_check.sv]
// Port-level checker for the motor move block and its bind.
`include "timed_or_encoder_motor_move_assert.svh"

module tomm_check (
  input logic clk,
  input logic rst,
  input logic cmd_valid,
  input logic cmd_ready,
  input logic res_valid,
  input logic res_ready
);

  // hold a stalled result word
  `TOMM_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid)
  // take one command word at a time
  `TOMM_ASSERT_NEXT(a_one_at_a_time, cmd_valid && cmd_ready, !cmd_ready)
  // a new command word never drops a pending result
  `TOMM_ASSERT_NEXT(a_keep_pending, cmd_valid && cmd_ready && res_valid && !res_ready, res_valid)
  // leave reset idle with no result and ready for a word
  `TOMM_ASSERT_RESET(a_reset_idle, rst, !res_valid && cmd_ready)

endmodule

bind timed_or_encoder_motor_move tomm_check u_tomm_check (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd.valid),
  .cmd_ready (cmd.ready),
  .res_valid (res.valid),
  .res_ready (res.ready)
);

[dv/timed_or_encoder_motor_move_checker.sv]
// Checker for the motor move block: predicts each result word and compares it.
`timescale 1ns / 100ps

module timed_or_encoder_motor_move_checker import tomm_pkg::*; (
  input  logic clk,
  input  logic rst,
  tomm_cmd_if  cmd,
  tomm_res_if  res,
  output int   fail_count,
  output int   pending
);

  typedef struct packed {
    logic signed [POWER_W-1:0] power;
    logic                      ready;
  } drive_word_t;

  drive_word_t drive_q[$];

  kind_t                     move_kind;
  logic [TIME_WIDTH-1:0]     ticks_left;
  longint                    target;
  bit                        forward;
  logic signed [POWER_W-1:0] after_hold;
  logic [MV_W-1:0]           ref_hold;
  logic signed [POWER_W-1:0] drive;
  bit                        idle_flag;
  int                        mismatches = 0;

  // Scale a power by ref/battery, truncate, keep at least 1 and clip to the limit.
  function automatic logic signed [POWER_W-1:0] scaled_power(
    input logic signed [POWER_W-1:0] p,
    input logic [MV_W-1:0]           ref_mv,
    input logic [MV_W-1:0]           bat_mv
  );
    int unsigned               mag;
    int unsigned               q;
    logic signed [POWER_W-1:0] m;
    if (p == 0) return '0;
    mag = (p < 0) ? -int'(p) : int'(p);
    if (bat_mv == 0) q = POWER_LIMIT;
    else q = (mag * ref_mv) / bat_mv;
    if (q == 0) q = 1;
    if (q > POWER_LIMIT) q = POWER_LIMIT;
    m = POWER_W'(q);
    return (p < 0) ? -m : m;
  endfunction

  task automatic advance_move();
    longint enc;
    longint amt;
    bit     finished;
    enc      = longint'(cmd.encoder_count);
    amt      = longint'(cmd.move_amount);
    finished = 1'b0;
    if (cmd.mode == MODE_TIMED || cmd.mode == MODE_DIST) begin
      after_hold = cmd.after_power;
      ref_hold   = cmd.ref_voltage_mv;
      drive      = scaled_power(cmd.start_power, cmd.ref_voltage_mv, cmd.battery_mv);
      idle_flag  = 1'b0;
      forward    = (cmd.start_power >= 0);
      if (cmd.mode == MODE_TIMED) begin
        move_kind  = KIND_TIMED;
        ticks_left = TIME_WIDTH'(cmd.move_amount);
      end else begin
        move_kind  = KIND_DIST;
        ticks_left = '0;
        target     = forward ? enc + amt : enc - amt;
      end
    end else if (cmd.mode == MODE_TICK) begin
      if (move_kind == KIND_TIMED) begin
        if (ticks_left <= 1) finished = 1'b1;
        else ticks_left = ticks_left - 1'b1;
      end else if (move_kind == KIND_DIST) begin
        finished = forward ? (enc >= target) : (enc <= target);
      end
    end
    if (finished) begin
      drive      = scaled_power(after_hold, ref_hold, cmd.battery_mv);
      idle_flag  = 1'b1;
      move_kind  = KIND_IDLE;
      ticks_left = '0;
    end
  endtask

  task automatic note_mismatch(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
  endtask

  always @(posedge clk) begin
    drive_word_t want;
    if (rst) begin
      move_kind  = KIND_IDLE;
      ticks_left = '0;
      target     = 0;
      forward    = 1'b1;
      after_hold = '0;
      ref_hold   = REF_MV_INIT;
      drive      = '0;
      idle_flag  = 1'b1;
      drive_q.delete();
    end else begin
      if (cmd.valid && cmd.ready) begin
        advance_move();
        drive_q.push_back('{power: drive, ready: idle_flag});
      end
      if (res.valid && res.ready) begin
        if (drive_q.size() == 0) begin
          note_mismatch("unexpected result word, motor_power", 0, int'(res.motor_power));
        end else begin
          want = drive_q.pop_front();
          if (res.motor_power !== want.power)
            note_mismatch("motor_power", int'(want.power), int'(res.motor_power));
          if (res.ready_res !== want.ready)
            note_mismatch("ready_res", int'(want.ready), int'(res.ready_res));
        end
      end
    end
    fail_count <= mismatches;
    pending    <= drive_q.size();
  end

endmodule

[dv/timed_or_encoder_motor_move_tb.sv]
// Testbench top for the motor move block: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 100ps

module timed_or_encoder_motor_move_tb;
  import tomm_pkg::*;

  // Mode 3 has no meaning; the block must ignore it.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  localparam int RANDOM_WORDS = 1550;   // counted random words before the run winds down
  localparam int CALM_WORDS   = 150;    // last stretch with no idling on either side
  localparam int LONG_HOLD    = 500;    // cycles of the long receiver hold-off
  localparam int DRAIN_CYCLES = 80;     // idle margin after the last predicted word
  localparam int CYCLE_LIMIT  = 1000000;

  logic clk = 1'b0;
  logic rst;

  tomm_cmd_if cmd_ch ();
  tomm_res_if res_ch ();

  int fail_count;
  int pending;
  int words_sent  = 0;
  int cycle_count = 0;
  bit calm        = 1'b0;
  int gap_odds    = 0;

  timed_or_encoder_motor_move DUT (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch)
  );

  timed_or_encoder_motor_move_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd_ch),
    .res        (res_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  // Hard stop: a hung handshake or a lost result ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Mostly in-range powers, with the occasional full 8-bit value (-128, +127 and friends).
  function automatic logic signed [POWER_W-1:0] rand_power();
    int v;
    if ($urandom_range(0, 9) == 0) return POWER_W'($urandom);
    v = $urandom_range(0, 200);
    return POWER_W'(v - 100);
  endfunction

  // Millivolts: mostly near the nominal 7.9 V, sometimes the extremes or any 14-bit value.
  function automatic logic [MV_W-1:0] rand_mv();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: return MV_W'($urandom);
      1: return MV_W'(16383);
      2: return MV_W'(1);
      default: return MV_W'($urandom_range(5000, 12000));
    endcase
  endfunction

  // Offer one command word and hold it until the block takes it. An optional idle burst
  // goes first; valid is only lowered here, never in the step where it is raised again.
  task automatic send_word(
    input logic [MODE_W-1:0]         m,
    input logic [AMOUNT_W-1:0]       amt,
    input logic signed [POWER_W-1:0] sp,
    input logic signed [POWER_W-1:0] ap,
    input logic [MV_W-1:0]           rmv,
    input logic signed [ENC_W-1:0]   enc,
    input logic [MV_W-1:0]           bmv
  );
    if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    cmd_ch.valid          <= 1'b1;
    cmd_ch.mode           <= m;
    cmd_ch.move_amount    <= amt;
    cmd_ch.start_power    <= sp;
    cmd_ch.after_power    <= ap;
    cmd_ch.ref_voltage_mv <= rmv;
    cmd_ch.encoder_count  <= enc;
    cmd_ch.battery_mv     <= bmv;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    words_sent++;
  endtask

  // A one millisecond tick; every field but encoder and battery is noise to the block.
  task automatic tick(input logic signed [ENC_W-1:0] enc, input logic [MV_W-1:0] bmv);
    send_word(MODE_TICK, AMOUNT_W'($urandom), POWER_W'($urandom), POWER_W'($urandom),
              MV_W'($urandom), enc, bmv);
  endtask

  // Receiver: random stalls, free-running stretches, and one long hold-off that lets the
  // block fill up and push back on the command channel.
  initial begin
    bit held_long;
    held_long = 1'b0;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (calm) begin
        res_ch.ready <= 1'b1;
        @(posedge clk);
      end else if (!held_long && words_sent >= 300) begin
        held_long = 1'b1;
        res_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        res_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
  end

  initial begin
    int                        counted;
    int                        kind_pick;
    int                        n_ticks;
    logic [MODE_W-1:0]         nm;
    logic [AMOUNT_W-1:0]       amt;
    logic signed [POWER_W-1:0] sp;
    logic signed [ENC_W-1:0]   e0;
    longint                    pos;
    longint                    tgt;
    longint                    step;
    bit                        fwd;

    counted = 0;

    // Drive every input to a known value while reset is held, then release reset.
    rst                   <= 1'b1;
    cmd_ch.valid          <= 1'b0;
    cmd_ch.mode           <= MODE_TICK;
    cmd_ch.move_amount    <= '0;
    cmd_ch.start_power    <= '0;
    cmd_ch.after_power    <= '0;
    cmd_ch.ref_voltage_mv <= '0;
    cmd_ch.encoder_count  <= '0;
    cmd_ch.battery_mv     <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- Directed part ----
    // Tick while idle, then the unused mode: both just repeat the reset outputs.
    tick(32'sd0, MV_W'(7900));
    send_word(MODE_UNUSED, 16'hFFFF, 8'sd127, -8'sd128, MV_W'(16383), 32'h7FFF_FFFF,
              MV_W'(16383));
    // Zero-length timed move ends on the first tick; full power both ways.
    send_word(MODE_TIMED, 16'd0, 8'sd100, -8'sd100, MV_W'(7900), 32'sd0, MV_W'(7900));
    tick(32'sd0, MV_W'(7900));
    // Power -128 with zero battery saturates; after power 127 with 1 mV battery clips.
    send_word(MODE_TIMED, 16'd2, -8'sd128, 8'sd127, MV_W'(16383), 32'sd0, MV_W'(0));
    tick(32'sd0, MV_W'(16383));
    tick(32'sd0, MV_W'(1));
    // Longest timed move, tiny ratio rounds up to 1, then overridden by a new start.
    send_word(MODE_TIMED, 16'hFFFF, 8'sd1, 8'sd0, MV_W'(1), 32'sd0, MV_W'(16383));
    tick(32'sd0, MV_W'(7900));
    send_word(MODE_TIMED, 16'd1, -8'sd1, -8'sd1, MV_W'(16383), 32'sd0, MV_W'(1));
    tick(32'sd0, MV_W'(0));
    // Forward distance from the top of the encoder range: target is out of reach.
    send_word(MODE_DIST, 16'hFFFF, 8'sd0, 8'sd50, MV_W'(7900), 32'h7FFF_FFFF, MV_W'(7900));
    tick(32'h7FFF_FFFF, MV_W'(7900));
    tick(32'h8000_0000, MV_W'(7900));
    // Backward from the bottom of the range, also out of reach; then overridden.
    send_word(MODE_DIST, 16'hFFFF, -8'sd100, 8'sd1, MV_W'(7900), 32'h8000_0000, MV_W'(7900));
    tick(32'h8000_0000, MV_W'(7900));
    // Zero-distance backward move with zero reference voltage ends on the first tick.
    send_word(MODE_DIST, 16'd0, -8'sd50, -8'sd128, MV_W'(0), 32'sd5, MV_W'(3));
    tick(32'sd5, MV_W'(7900));
    // Forward move of 10 degrees ends exactly on the target.
    send_word(MODE_DIST, 16'd10, 8'sd60, 8'sd0, MV_W'(8000), -32'sd5, MV_W'(8000));
    tick(32'sd4, MV_W'(8000));
    tick(32'sd5, MV_W'(8000));
    tick(32'sd5, MV_W'(8000));

    // ---- Random part: mostly complete moves with random content, some noise ----
    while (counted < RANDOM_WORDS) begin
      calm = (counted >= RANDOM_WORDS - CALM_WORDS);
      case ($urandom_range(0, 2))
        0: gap_odds = 0;
        1: gap_odds = 2;
        default: gap_odds = 6;
      endcase
      kind_pick = $urandom_range(0, 19);
      if (kind_pick < 9) begin
        // Timed move: short times mostly, an occasional huge one that gets overridden.
        amt = ($urandom_range(0, 15) == 0) ? AMOUNT_W'($urandom)
                                            : AMOUNT_W'($urandom_range(0, 12));
        send_word(MODE_TIMED, amt, rand_power(), rand_power(), rand_mv(), ENC_W'($urandom),
                  rand_mv());
        counted++;
        n_ticks = (amt > 20) ? $urandom_range(1, 6) : ((amt == 0) ? 1 : int'(amt));
        if ($urandom_range(0, 5) == 0) n_ticks = $urandom_range(0, n_ticks);
        repeat (n_ticks) begin
          tick(ENC_W'($urandom), rand_mv());
          counted++;
        end
        repeat ($urandom_range(0, 2)) begin
          tick(ENC_W'($urandom), rand_mv());
          counted++;
        end
      end else if (kind_pick < 18) begin
        // Distance move: walk the encoder toward the target, now and then backing off.
        sp  = rand_power();
        fwd = (sp >= 0);
        amt = ($urandom_range(0, 11) == 0) ? AMOUNT_W'($urandom)
                                            : AMOUNT_W'($urandom_range(0, 300));
        case ($urandom_range(0, 9))
          0: e0 = 32'h7FFF_FFFF - ENC_W'($urandom_range(0, 400));
          1: e0 = 32'h8000_0000 + ENC_W'($urandom_range(0, 400));
          default: e0 = ENC_W'($urandom);
        endcase
        send_word(MODE_DIST, amt, sp, rand_power(), rand_mv(), e0, rand_mv());
        counted++;
        pos     = longint'(e0);
        tgt     = fwd ? pos + longint'(amt) : pos - longint'(amt);
        n_ticks = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 4) : 40;
        for (int n = 0; n < n_ticks; n++) begin
          step = longint'($urandom_range(0, amt / 4 + 2));
          if ($urandom_range(0, 7) == 0) step = -step;
          pos = fwd ? pos + step : pos - step;
          if (pos > 64'sd2147483647) pos = 64'sd2147483647;
          if (pos < -64'sd2147483648) pos = -64'sd2147483648;
          tick(ENC_W'(pos), rand_mv());
          counted++;
          if (fwd ? (pos >= tgt) : (pos <= tgt)) break;
        end
        repeat ($urandom_range(0, 2)) begin
          tick(ENC_W'($urandom), rand_mv());
          counted++;
        end
      end else begin
        // Noise: any mode, any field value.
        repeat ($urandom_range(1, 4)) begin
          nm = MODE_W'($urandom_range(0, 3));
          send_word(nm, AMOUNT_W'($urandom), POWER_W'($urandom), POWER_W'($urandom),
                    MV_W'($urandom), ENC_W'($urandom), MV_W'($urandom));
          counted++;
        end
      end
    end
    cmd_ch.valid <= 1'b0;

    // Drain: wait for every predicted word, then a margin to catch stray results.
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
